// File: rtl/pmdh_pkg.sv
package pmdh_pkg;

    localparam logic [1:0] KIND_PEAK     = 2'd0;
    localparam logic [1:0] KIND_INACTIVE = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;

    localparam logic CFG_HOLD_TIME = 1'b0;
    localparam logic CFG_CLIP_THR  = 1'b1;

    localparam logic        [15:0] HOLD_TIME_RST = 16'd1500;
    localparam logic signed [15:0] CLIP_THR_RST  = -16'sd26;
    localparam logic signed [15:0] DB_SILENT     = -16'sd25600;
    localparam logic signed [15:0] DB_MAX        = 16'sd3072;

    // 20*log10(2)*256 in Q16
    localparam logic [26:0] DB_K = 27'd101008905;

    localparam int LOG_FRAC_BITS = 16;

    typedef struct packed {
        logic [31:0] now;
        logic [1:0]  chan;
        logic [1:0]  kind;
    } t_side;

endpackage

// File: rtl/pmdh_db_pipe.sv
module pmdh_db_pipe
    import pmdh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [18:0]        i_level,
    input  t_side              i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_db,
    output t_side              o_side
);

    // stage 0: normalize, 1..16: one squaring each, 17: scale, 18: round/clamp
    localparam int NSQ = LOG_FRAC_BITS;
    localparam int SP  = NSQ + 1;
    localparam int SD  = NSQ + 2;
    localparam int NS  = NSQ + 3;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;
    t_side         r_side [NS];

    logic [30:0]        r_m    [NSQ+1];
    logic [15:0]        r_frac [NSQ+1];
    logic signed [5:0]  r_eint [NSQ+1];
    logic               r_zero [NSQ+1];

    logic [47:0]        r_prod;
    logic               r_neg;
    logic               r_zero_p;
    logic signed [15:0] r_db;

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_db    = r_db;
    assign o_side  = r_side[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_side[0] <= i_side;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // normalize
    logic [4:0]  w_e;
    logic [30:0] w_m0;

    always_comb begin
        w_e = 5'd0;
        for (int i = 0; i < 19; i++) begin
            if (i_level[i]) begin
                w_e = 5'(i);
            end
        end
        w_m0 = {12'd0, i_level} << (5'd30 - w_e);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_m[0]    <= w_m0;
            r_frac[0] <= '0;
            r_eint[0] <= $signed({1'b0, w_e}) - 6'sd16;
            r_zero[0] <= (i_level == '0);
        end
    end

    // squaring stages
    for (genvar j = 1; j <= NSQ; j++) begin : g_sq
        logic [61:0] w_sq;
        logic [31:0] w_t;
        logic [15:0] w_frac;

        always_comb begin
            w_sq   = r_m[j-1] * r_m[j-1];
            w_t    = w_sq[61:30];
            w_frac = r_frac[j-1];
            w_frac[NSQ-j] = w_t[31];
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_m[j]    <= w_t[31] ? w_t[31:1] : w_t[30:0];
                r_frac[j] <= w_frac;
                r_eint[j] <= r_eint[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end
    end

    // scale log2 to 1/256 dB
    logic signed [21:0] w_l;
    logic [21:0]        w_abs;
    logic [20:0]        w_mag;

    always_comb begin
        w_l   = {r_eint[NSQ], r_frac[NSQ]};
        w_abs = w_l[21] ? 22'(-w_l) : w_l;
        w_mag = w_abs[20:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[SP]) begin
            r_prod   <= 48'(w_mag) * 48'(DB_K);
            r_neg    <= w_l[21];
            r_zero_p <= r_zero[NSQ];
        end
    end

    // round half away from zero, sign, clamp
    logic [47:0]        w_sum;
    logic signed [16:0] w_r;
    logic signed [16:0] w_dbw;
    logic signed [15:0] w_db;

    always_comb begin
        w_sum = r_prod + 48'h0000_8000_0000;
        w_r   = {1'b0, w_sum[47:32]};
        w_dbw = r_neg ? -w_r : w_r;
        if (r_zero_p || w_dbw < 17'(DB_SILENT)) begin
            w_db = DB_SILENT;
        end else if (w_dbw > 17'(DB_MAX)) begin
            w_db = DB_MAX;
        end else begin
            w_db = w_dbw[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[SD]) begin
            r_db <= w_db;
        end
    end

endmodule

// File: rtl/peak_meter_db_hold.sv
// Peak meter with peak hold.
// Slave stream: tuser = kind (peak, inactive, clear); tdata = peak_level,
// channel_request, now_ms from the low bit up. Each word gives one snapshot
// word on the master stream: meter_active, channels_shown, peak_db, hold_db,
// clip_flag, updated_ms from the low bit up.
// The snapshot is registered behind the level-to-dB path, a 19-stage
// pipeline (normalize, sixteen squaring multipliers of 31x31 bits, one
// scaling multiplier, round and clamp), and the meter state register
// doubles as the output register.
// Throughput: one word per cycle while the master stream is not stalled.
// Stall: a snapshot waiting on tready freezes the state; the pipeline keeps
// taking words until its stages are full, then tready falls.
// Reset: pipeline empty, state silent (-100 dB, inactive, stamps zero),
// hold_time_ms = 1500, clip_threshold = -26/256 dB.
// Config: write enable, index 0 hold_time_ms, 1 clip_threshold; write only
// while idle.
module peak_meter_db_hold
    import pmdh_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // peak_level[18:0], channel_request[26:19], now_ms[58:27]
    input  logic [1:0]  i_s_axis_tuser,  // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // meter_active[0], channels_shown[2:1], peak_db[18:3],
                                         // hold_db[34:19], clip_flag[35], updated_ms[67:36]
    input  logic        i_cfg_wen,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int STAMP_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

    logic [18:0] w_level;
    logic [7:0]  w_req;
    t_side       w_side_in;

    always_comb begin
        w_level = i_s_axis_tdata[18:0];
        w_req   = i_s_axis_tdata[26:19];
        w_side_in.kind = i_s_axis_tuser;
        w_side_in.now  = i_s_axis_tdata[58:27];
        if (w_req == 8'd0) begin
            w_side_in.chan = 2'd1;
        end else if (w_req > 8'd2) begin
            w_side_in.chan = 2'd2;
        end else begin
            w_side_in.chan = w_req[1:0];
        end
    end

    logic               w_p_valid;
    logic               w_p_ready;
    logic signed [15:0] w_p_db;
    t_side              w_p_side;

    pmdh_db_pipe u_db_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_level (w_level),
        .i_side  (w_side_in),
        .o_valid (w_p_valid),
        .i_ready (w_p_ready),
        .o_db    (w_p_db),
        .o_side  (w_p_side)
    );

    logic [15:0]           r_hold_time;
    logic signed [15:0]    r_clip_thr;
    logic                  r_out_v;
    logic                  r_active;
    logic [1:0]            r_chan;
    logic signed [15:0]    r_peak;
    logic signed [15:0]    r_held;
    logic                  r_clip;
    logic [STAMP_BITS-1:0] r_hold_stamp;
    logic [STAMP_BITS-1:0] r_upd_stamp;

    logic                  n_active;
    logic [1:0]            n_chan;
    logic signed [15:0]    n_peak;
    logic signed [15:0]    n_held;
    logic                  n_clip;
    logic [STAMP_BITS-1:0] n_hold_stamp;
    logic [STAMP_BITS-1:0] n_upd_stamp;

    logic [STAMP_BITS-1:0] w_now;
    logic [TIME_BITS-1:0]  w_elapsed;
    logic                  w_load;

    assign w_p_ready = !r_out_v || i_m_axis_tready;
    assign w_load    = w_p_valid && w_p_ready;

    always_comb begin
        w_now     = w_p_side.now[STAMP_BITS-1:0];
        w_elapsed = TIME_BITS'(w_now) - TIME_BITS'(r_hold_stamp);

        n_active     = r_active;
        n_chan       = r_chan;
        n_peak       = r_peak;
        n_held       = r_held;
        n_clip       = r_clip;
        n_hold_stamp = r_hold_stamp;
        n_upd_stamp  = r_upd_stamp;

        case (w_p_side.kind)
            KIND_PEAK: begin
                n_active    = 1'b1;
                n_chan      = w_p_side.chan;
                n_peak      = w_p_db;
                n_clip      = (w_p_db >= r_clip_thr);
                n_upd_stamp = w_now;
                if (w_p_db >= r_held || w_elapsed > TIME_BITS'(r_hold_time)) begin
                    n_held       = w_p_db;
                    n_hold_stamp = w_now;
                end
            end
            KIND_INACTIVE: begin
                n_active     = 1'b0;
                n_chan       = 2'd0;
                n_peak       = DB_SILENT;
                n_held       = DB_SILENT;
                n_clip       = 1'b0;
                n_hold_stamp = w_now;
                n_upd_stamp  = w_now;
            end
            KIND_CLEAR: begin
                n_active     = 1'b0;
                n_chan       = 2'd0;
                n_peak       = DB_SILENT;
                n_held       = DB_SILENT;
                n_clip       = 1'b0;
                n_hold_stamp = '0;
                n_upd_stamp  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time  <= HOLD_TIME_RST;
            r_clip_thr   <= CLIP_THR_RST;
            r_out_v      <= 1'b0;
            r_active     <= 1'b0;
            r_chan       <= 2'd0;
            r_peak       <= DB_SILENT;
            r_held       <= DB_SILENT;
            r_clip       <= 1'b0;
            r_hold_stamp <= '0;
            r_upd_stamp  <= '0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_HOLD_TIME: r_hold_time <= i_cfg_wdata;
                    CFG_CLIP_THR:  r_clip_thr  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (w_p_ready) begin
                r_out_v <= w_p_valid;
            end
            if (w_load) begin
                r_active     <= n_active;
                r_chan       <= n_chan;
                r_peak       <= n_peak;
                r_held       <= n_held;
                r_clip       <= n_clip;
                r_hold_stamp <= n_hold_stamp;
                r_upd_stamp  <= n_upd_stamp;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {4'd0, 32'(r_upd_stamp), r_clip, r_held, r_peak, r_chan, r_active};

endmodule
